### design/dks_pkg.sv
// DES key schedule package: shared constants, types and the permuted-choice functions.
// No dependencies; imported by every module of the block.
`default_nettype none

package dks_pkg;

	localparam int KeyW    = 64;
	localparam int HalfW   = 28;
	localparam int CdW     = 2 * HalfW;
	localparam int RkW     = 48;
	localparam int RndW    = 4;
	localparam int RndNumW = 5;
	localparam int Rounds  = 16;
	localparam int QDepth  = 2;

	localparam logic [RndW-1:0] LastRnd = RndW'(Rounds - 1);

	typedef logic [CdW-1:0] cd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam byte unsigned SEL_ONE [CdW] = '{
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
		8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
		8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
		8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
		8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
		8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
		8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
		8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};

	localparam byte unsigned SEL_TWO [RkW] = '{
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
		8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
		8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
		8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
		8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};

	// Bit 1 of the standard numbering is the MSB.
	function automatic cd_t pc1(input logic [KeyW-1:0] k);
		cd_t r;
		for (int i = 0; i < CdW; i++) begin
			r[CdW-1-i] = k[KeyW - int'(SEL_ONE[i])];
		end
		return r;
	endfunction

	function automatic logic [RkW-1:0] pc2(input cd_t cd);
		logic [RkW-1:0] r;
		for (int i = 0; i < RkW; i++) begin
			r[RkW-1-i] = cd[CdW - int'(SEL_TWO[i])];
		end
		return r;
	endfunction

	// Rounds 1, 2, 9 and 16 shift by one place, all others by two.
	function automatic logic two_places(input logic [RndW-1:0] rnd);
		logic r;
		case (rnd)
			4'd0, 4'd1, 4'd8, 4'd15: r = 1'b0;
			default:                 r = 1'b1;
		endcase
		return r;
	endfunction

	function automatic cd_t rotl(input cd_t cd, input logic two);
		logic [HalfW-1:0] c;
		logic [HalfW-1:0] d;
		c = cd[CdW-1:HalfW];
		d = cd[HalfW-1:0];
		if (two) begin
			return {c[HalfW-3:0], c[HalfW-1:HalfW-2], d[HalfW-3:0], d[HalfW-1:HalfW-2]};
		end else begin
			return {c[HalfW-2:0], c[HalfW-1], d[HalfW-2:0], d[HalfW-1]};
		end
	endfunction

endpackage

`default_nettype wire

### design/dks_front.sv
// Front end: takes a key beat, applies PC-1 and holds the halves until the queue has room.
// Depends on dks_pkg.
`default_nettype none

module dks_front import dks_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [KeyW-1:0] key,
	output logic                 busy,
	input  wire q_stat_t         q_stat,
	output logic                 push,
	output cd_t                  push_cd
);

	cd_t  cd_s1;
	logic vld_s1;
	logic accept;

	assign busy    = vld_s1 && q_stat.full;
	assign accept  = start && !busy;
	assign push    = vld_s1 && !q_stat.full;
	assign push_cd = cd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cd_s1 <= pc1(key);
		end
	end

endmodule

`default_nettype wire

### design/dks_queue.sv
// Two-entry queue of PC-1 halves between the front end and the round engine.
// Depends on dks_pkg.
`default_nettype none

module dks_queue import dks_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cd_t  push_cd,
	input  wire logic pop,
	output cd_t       pop_cd,
	output q_stat_t   q_stat
);

	cd_t        mem_q [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_stat = '{full: (cnt_q == 2'(QDepth)), empty: (cnt_q == 2'd0)};
	assign pop_cd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cd;
		end
	end

endmodule

`default_nettype wire

### design/dks_back.sv
// Round engine: per active cycle, rotates the halves and emits one PC-2 round key beat.
// Depends on dks_pkg.
`default_nettype none

module dks_back import dks_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire q_stat_t            q_stat,
	input  wire cd_t                pop_cd,
	output logic                    pop,
	output logic                    round_valid,
	output logic [RkW-1:0]          round_key,
	output logic [RndNumW-1:0]      round_number,
	output logic                    last
);

	cd_t             cd_q;
	logic [RndW-1:0] rnd_q;
	logic            active_q;

	// Take the next key on the final round so keys run without a gap.
	assign pop = (!active_q || rnd_q == LastRnd) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			rnd_q       <= '0;
			round_valid <= 1'b0;
		end else begin
			round_valid <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				rnd_q    <= '0;
			end else if (active_q) begin
				if (rnd_q == LastRnd) active_q <= 1'b0;
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cd_q <= rotl(pop_cd, two_places('0));
		end else if (active_q) begin
			cd_q <= rotl(cd_q, two_places(rnd_q + 1'b1));
		end
		if (active_q) begin
			round_key    <= pc2(cd_q);
			round_number <= {1'b0, rnd_q} + 1'b1;
			last         <= (rnd_q == LastRnd);
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && last |-> round_number == 5'd16)
		else $error("last beat not on round sixteen");

	a_rounds_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && round_number != 5'd1 |-> $past(round_valid))
		else $error("gap inside a key's round sequence");

	a_round_follows: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && !last |=> round_valid)
		else $error("round sequence cut short");

endmodule

`default_nettype wire

### design/des_key_schedule.sv
// DES key schedule top level: front end, two-entry queue and round engine.
// Depends on dks_pkg, dks_front, dks_queue and dks_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   key in   | start, busy            | key[63:0]
//   round out| round_valid (strobe)   | round_key[47:0], round_number, last
//
// Each key yields sixteen round key beats on consecutive cycles; the
// round engine emits one per cycle and takes the next queued key on the final round.
// When idle, a key runs through front register, queue, halves and round key registers.
// Up to three keys wait in the front register and queue; busy rises when all are full.
// The receiver cannot stall; every round key beat is on the ports for one cycle only.
// Reset clears all control state at once; there is no clearing pass.
`default_nettype none

module des_key_schedule import dks_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [KeyW-1:0]    key,
	output logic                    busy,
	output logic                    round_valid,
	output logic [RkW-1:0]          round_key,
	output logic [RndNumW-1:0]      round_number,
	output logic                    last
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	cd_t     push_cd;
	cd_t     pop_cd;

	dks_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.key     (key),
		.busy    (busy),
		.q_stat  (q_stat),
		.push    (push),
		.push_cd (push_cd)
	);

	dks_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cd (push_cd),
		.pop     (pop),
		.pop_cd  (pop_cd),
		.q_stat  (q_stat)
	);

	dks_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_cd       (pop_cd),
		.pop          (pop),
		.round_valid  (round_valid),
		.round_key    (round_key),
		.round_number (round_number),
		.last         (last)
	);

endmodule

`default_nettype wire

### tb/des_key_schedule_tb.sv
// Self-checking testbench for des_key_schedule: drives keys, predicts all sixteen
// round keys per key and checks every round key beat in order.
// Depends on dks_pkg and des_key_schedule.
`timescale 1ns / 1ps

module des_key_schedule_tb;
	import dks_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandomKeys = 400;
	localparam int DrainCycles = 20;

	// Permuted choice tables, first entry in the top byte.
	localparam logic [56*8-1:0] PERM_ONE = {
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
		8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
		8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
		8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
		8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
		8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
		8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
		8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};
	localparam logic [48*8-1:0] PERM_TWO = {
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
		8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
		8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
		8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
		8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};
	// Bit r set: round r+1 rotates by two places.
	localparam logic [15:0] DOUBLE_SHIFT = 16'b0111_1110_1111_1100;

	typedef struct packed {
		logic [KeyW-1:0] k;
		logic            drain_first;
		logic [6:0]      gap_pct;
	} key_req_t;

	typedef struct packed {
		logic [RkW-1:0]     rk;
		logic [RndNumW-1:0] rnd;
		logic               fin;
	} round_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [KeyW-1:0]    key = '0;
	logic               busy;
	logic               round_valid;
	logic [RkW-1:0]     round_key;
	logic [RndNumW-1:0] round_number;
	logic               last;

	key_req_t    key_reqs[$];
	round_beat_t round_keys_due[$];
	logic        key_taken = 1'b0;
	int          keys_total = 0;
	int          keys_taken = 0;
	int          beats_seen = 0;
	int          mismatches = 0;
	int          cycle_cnt = 0;

	des_key_schedule dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.key          (key),
		.busy         (busy),
		.round_valid  (round_valid),
		.round_key    (round_key),
		.round_number (round_number),
		.last         (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Expand one key into its sixteen round keys and queue them.
	task automatic push_round_keys(input logic [KeyW-1:0] k);
		logic [55:0]    cd;
		logic [27:0]    c;
		logic [27:0]    d;
		logic [55:0]    joined;
		logic [RkW-1:0] rk;
		round_beat_t    b;
		int             p;
		cd = '0;
		for (int i = 0; i < 56; i++) begin
			p = int'(PERM_ONE[(55-i)*8 +: 8]);
			cd = {cd[54:0], k[64-p]};
		end
		c = cd[55:28];
		d = cd[27:0];
		for (int r = 0; r < Rounds; r++) begin
			if (DOUBLE_SHIFT[r]) begin
				c = {c[25:0], c[27:26]};
				d = {d[25:0], d[27:26]};
			end else begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end
			joined = {c, d};
			rk = '0;
			for (int i = 0; i < 48; i++) begin
				p = int'(PERM_TWO[(47-i)*8 +: 8]);
				rk = {rk[46:0], joined[56-p]};
			end
			b.rk = rk;
			b.rnd = RndNumW'(r + 1);
			b.fin = (r == Rounds - 1);
			round_keys_due.push_back(b);
		end
	endtask

	task automatic add_key(input logic [KeyW-1:0] k, input logic drain, input int pct);
		key_req_t q;
		q.k = k;
		q.drain_first = drain;
		q.gap_pct = 7'(pct);
		key_reqs.push_back(q);
		keys_total++;
	endtask

	// Driver: present the head key at the falling edge, hold it until taken.
	always @(negedge clk) begin
		logic            go;
		logic [KeyW-1:0] nk;
		go = start;
		nk = key;
		if (arst_n) begin
			if (start && key_taken) begin
				void'(key_reqs.pop_front());
				go = 1'b0;
			end
			if (!go && key_reqs.size() > 0) begin
				if (key_reqs[0].drain_first && round_keys_due.size() != 0) begin
					go = 1'b0;
				end else if ($urandom_range(99) < key_reqs[0].gap_pct) begin
					go = 1'b0;
				end else begin
					go = 1'b1;
					nk = key_reqs[0].k;
				end
			end
			// scramble the idle bus now and then
			if (!go && $urandom_range(3) == 0) begin
				nk = {$urandom, $urandom};
			end
		end
		start <= go;
		key <= nk;
	end

	// Monitor: predict on every key beat, check every round key beat.
	always @(posedge clk) begin
		round_beat_t e;
		if (arst_n) begin
			key_taken <= start && !busy;
			if (start && !busy) begin
				push_round_keys(key);
				keys_taken++;
			end
			if (round_valid) begin
				beats_seen++;
				if (round_keys_due.size() == 0) begin
					$error("unexpected round key beat: round_key=%h round_number=%0d last=%b",
						round_key, round_number, last);
					mismatches++;
				end else begin
					e = round_keys_due.pop_front();
					if (round_key !== e.rk) begin
						$error("round_key expected %h actual %h", e.rk, round_key);
						mismatches++;
					end
					if (round_number !== e.rnd) begin
						$error("round_number expected %0d actual %0d", e.rnd, round_number);
						mismatches++;
					end
					if (last !== e.fin) begin
						$error("last expected %b actual %b", e.fin, last);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timed out after %0d cycles", cycle_cnt);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [KeyW-1:0] base;
		int              pct;
		// Extremes, the classic key, weak keys, parity-only changes, single bits and patterns.
		add_key(64'h0000_0000_0000_0000, 1'b0, 14);
		add_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 14);
		add_key(64'h1334_5779_9BBC_DFF1, 1'b0, 14);
		add_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101, 1'b0, 14);
		add_key(64'h0101_0101_0101_0101, 1'b0, 14);
		add_key(64'hFEFE_FEFE_FEFE_FEFE, 1'b0, 14);
		add_key(64'hE0E0_E0E0_F1F1_F1F1, 1'b0, 14);
		add_key(64'h1F1F_1F1F_0E0E_0E0E, 1'b0, 14);
		add_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 14);
		add_key(64'h5555_5555_5555_5555, 1'b0, 14);
		add_key(64'h8000_0000_0000_0000, 1'b0, 14);
		add_key(64'h0000_0000_0000_0001, 1'b0, 14);
		add_key(64'h0000_0000_0000_0002, 1'b0, 14);
		add_key(64'h4000_0000_0000_0000, 1'b0, 14);
		add_key(64'hFEFE_FEFE_FEFE_FEFE ^ 64'h0101_0101_0101_0101, 1'b0, 14);
		add_key(64'h0123_4567_89AB_CDEF, 1'b0, 14);
		add_key(64'hFFFF_FFFF_0000_0000, 1'b0, 14);
		add_key(64'h0000_0000_FFFF_FFFF, 1'b0, 14);
		for (int i = 0; i < RandomKeys; i++) begin
			pct = (i < RandomKeys / 3) ? 14 : (i < 2 * RandomKeys / 3) ? 82 : 0;
			base = {$urandom, $urandom};
			case ($urandom_range(9))
				0: base = base ^ (64'(32'($urandom)) & 64'h0101_0101_0101_0101);
				1: base = 64'h1 << $urandom_range(63);
				2: base = ~(64'h1 << $urandom_range(63));
				default: ;
			endcase
			add_key(base, (i % (RandomKeys / 3) == 0) || ($urandom_range(39) == 0), pct);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (keys_taken != keys_total || round_keys_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("Checked %0d keys and %0d round key beats in %0d cycles,", keys_taken,
			beats_seen, cycle_cnt);
		$display("with sender gaps of 14, 82 and 0 percent and full drains between bursts.");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
